### hdl/sdrrip_pkg.sv
// Package for the SHiP/DRRIP replacement core: sizes, payload structs, row layout,
// controller command and status structs, and the leader-set decode function.
// Depends on nothing; every other file of the core imports it.
package sdrrip_pkg;

    // Geometry of the cache and of the predictor tables.
    // SETS, WAYS and SETS / LEADER_SETS are powers of two.
    localparam int SETS           = 2048;
    localparam int WAYS           = 16;
    localparam int LEADER_SETS    = 64;
    localparam int SIG_BITS       = 6;
    localparam int SEL_BITS       = 10;

    localparam int SET_BITS       = $clog2(SETS);
    localparam int WAY_BITS       = $clog2(WAYS);
    localparam int SIG_COUNT      = 1 << SIG_BITS;
    localparam int STRIDE         = SETS / LEADER_SETS;
    localparam int HALF_STRIDE    = STRIDE / 2;

    // The clearing sweep covers both the set rows and the reuse counters.
    localparam int CLEAR_LEN      = (SETS > SIG_COUNT) ? SETS : SIG_COUNT;
    localparam int CLR_BITS       = $clog2(CLEAR_LEN);

    localparam logic [1:0] RV_MAX  = 2'd3;
    localparam logic [1:0] CTR_MAX = 2'd3;
    localparam logic [1:0] CTR_RST = 2'd1;
    localparam logic [SEL_BITS-1:0] SEL_MAX  = {SEL_BITS{1'b1}};
    localparam logic [SEL_BITS-1:0] SEL_MID  = SEL_MAX >> 1;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Operation codes.
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        LEAD_NONE,
        LEAD_SRRIP,
        LEAD_BRRIP
    } leader_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic                op;
        logic [SET_BITS-1:0] set_index;
        logic [WAY_BITS-1:0] way_index;
        logic                hit;
        logic [SIG_BITS-1:0] signature;
    } req_t;

    typedef struct packed {
        logic [WAY_BITS-1:0] victim_way;
        logic [1:0]          inserted_value;
        logic [SEL_BITS-1:0] selector_value;
    } rsp_t;

    // One set of the cache: a signature and a re-reference value per way.
    typedef struct packed {
        logic [WAYS-1:0][SIG_BITS-1:0] sigs;
        logic [WAYS-1:0][1:0]          rrpv;
    } row_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic exec;
        logic finish_miss;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_miss;
    } dp_sts_t;

    // Leader decode: the set at half stride leads for bimodal insertion,
    // the set at the start of a stride leads for static insertion.
    function automatic leader_t leader_kind(input logic [SET_BITS-1:0] s);
        logic [SET_BITS-1:0] q;
        logic [SET_BITS-1:0] r;
        leader_t             k;
        q = SET_BITS'(s / STRIDE);
        r = SET_BITS'(s % STRIDE);
        k = LEAD_NONE;
        if (32'(q) < 32'(LEADER_SETS))
        begin
            if (32'(r) == 32'(HALF_STRIDE))
            begin
                k = LEAD_BRRIP;
            end
            else if (r == '0)
            begin
                k = LEAD_SRRIP;
            end
        end
        return k;
    endfunction

endpackage

### hdl/ship_drrip_cache_replacement_core.sv
// Top level of the SHiP-lite / DRRIP replacement core: controller plus datapath.
// Depends on sdrrip_pkg, sdrrip_ctrl and sdrrip_dp.
//
//  channel   signals                 transfer when
//  request   start, busy, request    start high and busy low at a rising edge
//  result    done, result            done high for one cycle, always taken
//
// A find or a hit update goes through the registered set row read and then a step
// that works on the row and writes it back; a miss update adds a further step
// because the victim's reuse counter is read from the counter memory only once
// the row is known. The last step loads the result register; when done shows the
// result, busy is already low. After reset a clearing sweep over every set row and
// every reuse counter (one set row per cycle) holds busy high. The receiver cannot stall results.
module ship_drrip_cache_replacement_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sdrrip_pkg::req_t request,
    output logic             done,
    output sdrrip_pkg::rsp_t result
);
    import sdrrip_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer.
    sdrrip_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Tables and arithmetic.
    sdrrip_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result),
        .done    (done)
    );

`ifndef ASSERT_OFF
    // A result only follows a busy cycle of the item that made it.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a busy cycle before it");

    // An accepted item keeps the core busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting an item");

    // Results never come in consecutive cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");
`endif

endmodule

### hdl/sdrrip_ctrl.sv
// Controller of the replacement core: clearing sweep, accept, execute and the
// extra miss step. Depends on sdrrip_pkg.
module sdrrip_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sdrrip_pkg::dp_sts_t sts,
    output sdrrip_pkg::dp_cmd_t cmd
);
    import sdrrip_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_miss ? ST_MISS : ST_IDLE;
            end
            ST_MISS:
            begin
                cmd.finish_miss = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### hdl/sdrrip_dp.sv
// Datapath of the replacement core: set row memory, reuse counter memory,
// duel selector, LFSR and result register. Depends on sdrrip_pkg.
module sdrrip_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sdrrip_pkg::req_t    request,
    input  sdrrip_pkg::dp_cmd_t cmd,
    output sdrrip_pkg::dp_sts_t sts,
    output sdrrip_pkg::rsp_t    result,
    output logic                done
);
    import sdrrip_pkg::*;

    row_t                row_mem [SETS];
    logic [1:0]          ctr_mem [SIG_COUNT];

    req_t                req_reg;
    row_t                row_rd_reg;
    logic [1:0]          ctr_rd_reg;
    logic [1:0]          ctr_sig_reg;
    logic [SIG_BITS-1:0] old_reg;
    logic [CLR_BITS-1:0] clr_cnt_reg;
    logic [SEL_BITS-1:0] sel_reg;
    logic [SEL_BITS-1:0] sel_next;
    logic [15:0]         lfsr_reg;
    logic [15:0]         lfsr_next;
    rsp_t                result_reg;
    rsp_t                result_next;
    logic                done_reg;

    logic [WAY_BITS-1:0] way;
    logic [SIG_BITS-1:0] sig;
    leader_t             kind;
    logic                is_find;
    logic                is_hit;
    logic [1:0]          top;
    logic [1:0]          delta;
    row_t                find_row;
    row_t                hit_row;
    row_t                miss_row;
    logic [WAY_BITS-1:0] victim;
    logic [SIG_BITS-1:0] old_c;
    logic [1:0]          ctr_dec;
    logic [1:0]          ctr_eff;
    logic [15:0]         lfsr_draw;
    logic [1:0]          bimodal;
    logic                use_bimodal;
    logic [1:0]          ins;

    logic                row_we;
    logic [SET_BITS-1:0] row_waddr;
    row_t                row_wdata;
    logic                ctr_we;
    logic [SIG_BITS-1:0] ctr_waddr;
    logic [1:0]          ctr_wdata;
    logic                ctr_re;
    logic [SIG_BITS-1:0] ctr_raddr;

    assign way     = req_reg.way_index;
    assign sig     = req_reg.signature;
    assign kind    = leader_kind(req_reg.set_index);
    assign is_find = (req_reg.op == OP_FIND);
    assign is_hit  = req_reg.hit;
    assign old_c   = row_rd_reg.sigs[way];

    assign sts.need_miss  = !is_find && !is_hit;
    assign sts.clear_last = (32'(clr_cnt_reg) == 32'(CLEAR_LEN - 1));

    // Victim search: age the whole set by the same amount, take the first way at 3.
    always_comb
    begin
        top = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_rd_reg.rrpv[w] > top)
            begin
                top = row_rd_reg.rrpv[w];
            end
        end
        delta    = RV_MAX - top;
        find_row = row_rd_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            find_row.rrpv[w] = row_rd_reg.rrpv[w] + delta;
        end
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (find_row.rrpv[w] == RV_MAX)
            begin
                victim = WAY_BITS'(w);
            end
        end
    end

    // Hit: clear the way's value, store the signature, move the selector in leaders.
    always_comb
    begin
        hit_row            = row_rd_reg;
        hit_row.rrpv[way]  = 2'd0;
        hit_row.sigs[way]  = sig;
        sel_next           = sel_reg;
        if (kind == LEAD_SRRIP && sel_reg != SEL_MAX)
        begin
            sel_next = sel_reg + 1'b1;
        end
        else if (kind == LEAD_BRRIP && sel_reg != '0)
        begin
            sel_next = sel_reg - 1'b1;
        end
    end

    // Miss: lower the victim's counter, then pick the insertion value.
    always_comb
    begin
        ctr_dec     = (ctr_rd_reg != 2'd0) ? ctr_rd_reg - 2'd1 : ctr_rd_reg;
        ctr_eff     = (old_reg == sig) ? ctr_dec : ctr_sig_reg;
        lfsr_draw   = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 16'h0000);
        bimodal     = (lfsr_draw[4:0] == 5'd0) ? 2'd2 : 2'd3;
        use_bimodal = 1'b0;
        if (ctr_eff >= 2'd2)
        begin
            ins = 2'd0;
        end
        else if (ctr_eff == 2'd0)
        begin
            ins = RV_MAX;
        end
        else if (kind == LEAD_SRRIP)
        begin
            ins = 2'd2;
        end
        else if (kind == LEAD_BRRIP)
        begin
            ins         = bimodal;
            use_bimodal = 1'b1;
        end
        else if (sel_reg >= SEL_MID)
        begin
            ins = 2'd2;
        end
        else
        begin
            ins         = bimodal;
            use_bimodal = 1'b1;
        end
        miss_row           = row_rd_reg;
        miss_row.rrpv[way] = ins;
        miss_row.sigs[way] = sig;
        lfsr_next          = (cmd.finish_miss && use_bimodal) ? lfsr_draw : lfsr_reg;
    end

    // Memory port steering.
    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = req_reg.set_index;
        row_wdata = miss_row;
        ctr_we    = 1'b0;
        ctr_waddr = old_reg;
        ctr_wdata = ctr_dec;
        if (cmd.clear_step)
        begin
            row_we    = (32'(clr_cnt_reg) < 32'(SETS));
            row_waddr = clr_cnt_reg[SET_BITS-1:0];
            row_wdata = '{sigs: '0, rrpv: '1};
            ctr_we    = (32'(clr_cnt_reg) < 32'(SIG_COUNT));
            ctr_waddr = clr_cnt_reg[SIG_BITS-1:0];
            ctr_wdata = CTR_RST;
        end
        else if (cmd.exec && is_find)
        begin
            row_we    = 1'b1;
            row_wdata = find_row;
        end
        else if (cmd.exec && is_hit)
        begin
            row_we    = 1'b1;
            row_wdata = hit_row;
            ctr_we    = 1'b1;
            ctr_waddr = sig;
            ctr_wdata = (ctr_rd_reg != CTR_MAX) ? ctr_rd_reg + 2'd1 : ctr_rd_reg;
        end
        else if (cmd.finish_miss)
        begin
            row_we = 1'b1;
            ctr_we = 1'b1;
        end
        ctr_re    = cmd.load || (cmd.exec && sts.need_miss);
        ctr_raddr = cmd.load ? request.signature : old_c;
    end

    // Set row memory.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (cmd.load)
        begin
            row_rd_reg <= row_mem[request.set_index];
        end
    end

    // Reuse counter memory.
    always_ff @(posedge clk)
    begin
        if (ctr_we)
        begin
            ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (ctr_re)
        begin
            ctr_rd_reg <= ctr_mem[ctr_raddr];
        end
    end

    // Item and working payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.exec)
        begin
            ctr_sig_reg <= ctr_rd_reg;
            old_reg     <= old_c;
        end
        result_reg <= result_next;
    end

    // Result selection.
    always_comb
    begin
        result_next                = result_reg;
        if (cmd.exec && !sts.need_miss)
        begin
            result_next.victim_way     = is_find ? victim : '0;
            result_next.inserted_value = 2'd0;
            result_next.selector_value = is_find ? sel_reg : sel_next;
        end
        else if (cmd.finish_miss)
        begin
            result_next.victim_way     = '0;
            result_next.inserted_value = ins;
            result_next.selector_value = sel_reg;
        end
    end

    // Control state: sweep counter, selector, LFSR and transfer strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            sel_reg     <= SEL_MID;
            lfsr_reg    <= LFSR_SEED;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step && !sts.clear_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec && !is_find && is_hit)
            begin
                sel_reg <= sel_next;
            end
            lfsr_reg <= lfsr_next;
            done_reg <= (cmd.exec && !sts.need_miss) || cmd.finish_miss;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

### dv/tb.sv
// Self-checking testbench for the SHiP-lite / DRRIP replacement core.
// Depends on sdrrip_pkg and ship_drrip_cache_replacement_core; predicts every result itself.
`timescale 1ns / 1ps

module tb;
    import sdrrip_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    rsp_t result;

    // Predictor state.
    logic [1:0]          rrpv_mem [SETS*WAYS];
    logic [SIG_BITS-1:0] sig_mem  [SETS*WAYS];
    logic [1:0]          reuse_ctr [SIG_COUNT];
    logic [SEL_BITS-1:0] selector;
    logic [15:0]         lfsr;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   error_count;
    int   cycle_count;
    int   burst_left;
    int   gap_left;

    ship_drrip_cache_replacement_core uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always #10 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    // Leader class of a set, worked out independently of the package decode.
    function automatic leader_t set_leader(input int s);
        int q;
        int r;
        q = s / STRIDE;
        r = s % STRIDE;
        if (q >= LEADER_SETS)
            return LEAD_NONE;
        if (r == HALF_STRIDE)
            return LEAD_BRRIP;
        if (r == 0)
            return LEAD_SRRIP;
        return LEAD_NONE;
    endfunction

    function automatic logic [1:0] draw_bimodal();
        logic lsb;
        lsb = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb)
            lfsr = lfsr ^ 16'hB400;
        return (lfsr[4:0] == 5'd0) ? 2'd2 : 2'd3;
    endfunction

    // Applies one accepted request to the predictor and returns the expected result.
    function automatic rsp_t predict_replacement(input req_t rq);
        rsp_t    rs;
        int      base;
        int      idx;
        int      w;
        logic [1:0] top;
        logic [1:0] ctr;
        logic [SIG_BITS-1:0] old_sig;
        leader_t kind;
        base = int'(rq.set_index) * WAYS;
        rs = '0;
        if (rq.op == OP_FIND)
        begin
            top = '0;
            for (w = 0; w < WAYS; w++)
                if (rrpv_mem[base+w] > top)
                    top = rrpv_mem[base+w];
            for (w = 0; w < WAYS; w++)
                rrpv_mem[base+w] = rrpv_mem[base+w] + (2'd3 - top);
            for (w = WAYS - 1; w >= 0; w--)
                if (rrpv_mem[base+w] == 2'd3)
                    rs.victim_way = w[WAY_BITS-1:0];
        end
        else
        begin
            idx = base + int'(rq.way_index);
            kind = set_leader(int'(rq.set_index));
            if (rq.hit)
            begin
                rs.inserted_value = 2'd0;
                if (reuse_ctr[rq.signature] != 2'd3)
                    reuse_ctr[rq.signature]++;
                if (kind == LEAD_SRRIP && selector != '1)
                    selector++;
                else if (kind == LEAD_BRRIP && selector != '0)
                    selector--;
            end
            else
            begin
                old_sig = sig_mem[idx];
                if (reuse_ctr[old_sig] != 2'd0)
                    reuse_ctr[old_sig]--;
                ctr = reuse_ctr[rq.signature];
                if (ctr >= 2'd2)
                    rs.inserted_value = 2'd0;
                else if (ctr == 2'd0)
                    rs.inserted_value = 2'd3;
                else if (kind == LEAD_SRRIP)
                    rs.inserted_value = 2'd2;
                else if (kind == LEAD_BRRIP)
                    rs.inserted_value = draw_bimodal();
                else if (selector >= ({SEL_BITS{1'b1}} >> 1))
                    rs.inserted_value = 2'd2;
                else
                    rs.inserted_value = draw_bimodal();
            end
            rrpv_mem[idx] = rs.inserted_value;
            sig_mem[idx] = rq.signature;
        end
        rs.selector_value = selector;
        return rs;
    endfunction

    function automatic req_t make_req(input logic op, input int s, input int w,
                                      input logic h, input int sg);
        req_t rq;
        rq.op = op;
        rq.set_index = s[SET_BITS-1:0];
        rq.way_index = w[WAY_BITS-1:0];
        rq.hit = h;
        rq.signature = sg[SIG_BITS-1:0];
        return rq;
    endfunction

    // Driver: bursts of requests separated by random gaps, changes on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n || (start && busy))
        begin
            // Hold or wait for reset.
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            start <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            start <= 1'b1;
            request <= pending_reqs[0];
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
            start <= 1'b0;
    end

    // Monitor: records each request transfer and compares each result with the
    // oldest expectation.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && start && !busy)
        begin
            expected_rsps.push_back(predict_replacement(request));
            void'(pending_reqs.pop_front());
        end
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                rsp_t want;
                want = expected_rsps.pop_front();
                if (result.victim_way !== want.victim_way)
                    report("victim_way", result.victim_way, want.victim_way);
                if (result.inserted_value !== want.inserted_value)
                    report("inserted_value", result.inserted_value, want.inserted_value);
                if (result.selector_value !== want.selector_value)
                    report("selector_value", result.selector_value, want.selector_value);
            end
        end
        if (cycle_count > 200000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int i;
        int s;
        int pick;
        int hot_sets [8];
        clk = 0;
        rst_n = 0;
        start = 0;
        request = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        for (i = 0; i < SETS*WAYS; i++)
        begin
            rrpv_mem[i] = 2'd3;
            sig_mem[i] = '0;
        end
        for (i = 0; i < SIG_COUNT; i++)
            reuse_ctr[i] = 2'd1;
        selector = {SEL_BITS{1'b1}} >> 1;
        lfsr = 16'hACE1;

        // Directed: extremes, both operations, leader kinds, counter saturation.
        pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FIND, SETS-1, WAYS-1, 1, SIG_COUNT-1));
        pending_reqs.push_back(make_req(OP_UPDATE, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(OP_UPDATE, HALF_STRIDE, WAYS-1, 1, SIG_COUNT-1));
        pending_reqs.push_back(make_req(OP_UPDATE, HALF_STRIDE, 3, 0, 5));
        pending_reqs.push_back(make_req(OP_UPDATE, 0, 4, 0, 5));
        pending_reqs.push_back(make_req(OP_UPDATE, 5, 5, 0, 9));
        pending_reqs.push_back(make_req(OP_UPDATE, SETS-1, WAYS-1, 0, SIG_COUNT-1));
        for (i = 0; i < 4; i++)
            pending_reqs.push_back(make_req(OP_UPDATE, 7, i, 1, 12));
        // Miss into the way that already holds the same signature: shared counter.
        pending_reqs.push_back(make_req(OP_UPDATE, 7, 0, 0, 12));
        for (i = 0; i < 3; i++)
            pending_reqs.push_back(make_req(OP_UPDATE, 9, i, 0, 0));
        pending_reqs.push_back(make_req(OP_UPDATE, 9, 3, 0, 0));
        pending_reqs.push_back(make_req(OP_FIND, 7, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FIND, 9, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FIND, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_UPDATE, 1234, 10, 1, 42));

        // Random: traffic concentrated on a few sets, leaders among them.
        for (i = 0; i < 8; i++)
            hot_sets[i] = (i < 3) ? (i * STRIDE + ((i % 2) ? HALF_STRIDE : 0))
                                  : $urandom_range(0, SETS-1);
        for (i = 0; i < 550; i++)
        begin
            pick = $urandom_range(0, 9);
            s = (pick < 8) ? hot_sets[$urandom_range(0, 7)] : $urandom_range(0, SETS-1);
            pending_reqs.push_back(make_req($urandom_range(0, 2) != 0, s,
                $urandom_range(0, WAYS-1), $urandom_range(0, 1) != 0,
                ($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, SIG_COUNT-1))));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        wait (pending_reqs.size() == 0 && !start);
        wait (expected_rsps.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
